>>> rtl/core/mtos_pkg.sv
// Shared types and codes for the move-to-top order stack.
package mtos_pkg;

  localparam int ID_FIELD_W    = 8;
  localparam int COUNT_FIELD_W = 5;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [ID_FIELD_W-1:0] window_id;
  } req_t;

  typedef struct packed {
    logic                     was_present;
    logic                     dropped;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic [ID_FIELD_W-1:0]    top_id;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                  add_en;
    logic                  del_en;
    logic [ID_FIELD_W-1:0] id;
  } cell_cmd_t;

endpackage

>>> rtl/core/mtos_chan_if.sv
// Valid/ready channel carrying one payload of type T.
interface mtos_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/move_to_top_order_stack.sv
// Move-to-top order stack: a chain of DEPTH cells held top first.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side keeps up.
// The cycle path is the id compare plus the hit ripple through all DEPTH cells.
// Reset clears the entry count and the result valid; slot contents are not cleared.
module move_to_top_order_stack #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  mtos_chan_if.sink   req,
  mtos_chan_if.source rsp
);
  import mtos_pkg::*;

  localparam int IdW  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            rsp_valid;
  rsp_t            rsp_data;

  logic [IdW-1:0]  id_w;
  logic            id_nz;
  logic            accept;
  logic            found;
  logic            full;
  logic            is_add;
  logic            drop;
  logic [IdW-1:0]  top_w;
  cell_cmd_t       cmd;

  logic [IdW-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] valid;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign id_w   = req.data.window_id[IdW-1:0];
  assign id_nz  = |id_w;
  assign found  = hit[DEPTH-1];
  assign full   = (count == CntW'(DEPTH));
  assign is_add = (req.data.kind == KIND_ADD);
  assign drop   = id_nz && is_add && !found && full;

  always_comb begin
    cmd        = '0;
    cmd.id     = ID_FIELD_W'(id_w);
    cmd.add_en = accept && id_nz && is_add && !drop;
    cmd.del_en = accept && id_nz && (req.data.kind == KIND_DELETE);
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [IdW-1:0] above;
    logic [IdW-1:0] below;
    logic           hit_in;

    assign valid[k] = (CntW'(k) < count);

    if (k == 0) begin : g_first
      assign above  = id_w;
      assign hit_in = 1'b0;
    end else begin : g_rest
      assign above  = cell_data[k-1];
      assign hit_in = hit[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign below = cell_data[k];
    end else begin : g_inner
      assign below = cell_data[k+1];
    end

    mtos_cell #(.W(IdW)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .valid   (valid[k]),
      .hit_in  (hit_in),
      .above   (above),
      .below   (below),
      .hit_out (hit[k]),
      .match   (match[k]),
      .data    (cell_data[k])
    );
  end

  always_comb begin
    count_next = count;
    if (id_nz && !drop) begin
      if (found) begin
        count_next = count - CntW'(1);
      end
      if (is_add) begin
        count_next = count_next + CntW'(1);
      end
    end
  end

  // top slot after the request: zero when empty, the new id on an add, else taken from the first two cells
  always_comb begin
    priority if (count_next == '0) begin
      top_w = '0;
    end else if (id_nz && is_add && !drop) begin
      top_w = id_w;
    end else if (id_nz && hit[0]) begin
      top_w = cell_data[1];
    end else begin
      top_w = cell_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data.was_present <= id_nz && found;
      rsp_data.dropped     <= drop;
      rsp_data.entry_count <= COUNT_FIELD_W'(count_next);
      rsp_data.top_id      <= ID_FIELD_W'(top_w);
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_ids_distinct: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("identifier held in more than one slot");

  a_drop_only_new: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.dropped |-> !rsp.data.was_present)
    else $error("dropped add reported a present identifier");

  a_add_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.add_en |=> (count != '0) && (cell_data[0] == $past(id_w)))
    else $error("add did not land on top");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count moved without a request");

endmodule

>>> rtl/core/mtos_cell.sv
// One stack slot: compares the broadcast id and shifts toward either neighbor.
module mtos_cell #(
  parameter int W = 8
) (
  input  logic              clk,
  input  mtos_pkg::cell_cmd_t cmd,
  input  logic              valid,
  input  logic              hit_in,
  input  logic [W-1:0]      above,
  input  logic [W-1:0]      below,
  output logic              hit_out,
  output logic              match,
  output logic [W-1:0]      data
);
  import mtos_pkg::*;

  logic [W-1:0] data_next;

  assign match   = valid && (data == cmd.id[W-1:0]);
  assign hit_out = hit_in || match;

  // add: everything from the top down to the old copy moves one slot deeper
  // delete: everything from the match on pulls up from below
  always_comb begin
    priority if (cmd.add_en && !hit_in) begin
      data_next = above;
    end else if (cmd.del_en && hit_out) begin
      data_next = below;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
